// ----- src/lpmr_pkg.sv -----
// Package: word types, status codes and controller/datapath interface structs.
`timescale 1ns / 1ps
package lpmr_pkg;

	localparam int HEADER_BYTES = 4;

	localparam logic [1:0] OP_BEGIN = 2'd0;
	localparam logic [1:0] OP_PUSH  = 2'd1;
	localparam logic [1:0] OP_POP   = 2'd2;
	localparam logic [1:0] OP_NONE  = 2'd3;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;
	localparam logic [1:0] ST_SEQ   = 2'd3;

	typedef struct packed {
		logic [1:0] operation;
		logic [9:0] msg_length;
		logic [7:0] data_in;
		logic [9:0] read_limit;
	} in_t;

	typedef struct packed {
		logic [1:0] status;
		logic [7:0] data_out;
		logic [9:0] popped_length;
		logic       first_byte;
		logic       last_byte;
		logic       kept;
		logic [9:0] free_bytes;
		logic       is_empty;
	} out_t;

	typedef struct packed {
		logic       load;
		logic       hdr0;
		logic       hdr1;
		logic       push;
		logic       rd_h0;
		logic       rd_h1;
		logic       hdr_take;
		logic       pop_chk;
		logic       pl_take;
		logic       set_status;
		logic [1:0] status;
		logic       emit;
	} cmd_t;

	typedef struct packed {
		logic [1:0] op;
		logic       wl_zero;
		logic       rl_zero;
		logic       empty;
		logic       room;
		logic       out_free;
	} stat_t;

endpackage

// ----- src/lpmr_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module lpmr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- src/lpmr_ctrl.sv -----
// Controller: sequences memory accesses and pointer updates for one word.
`timescale 1ns / 1ps
module lpmr_ctrl import lpmr_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	input  stat_t st,
	output cmd_t  cmd
);

	typedef enum logic [2:0] {
		S_IDLE, S_EXEC, S_HDR1, S_RDH1, S_RDH2, S_POP, S_POPD, S_DONE
	} state_t;

	state_t state_q, state_d;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		cmd = '0;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				state_d = S_DONE;
				case (st.op)
					OP_BEGIN: begin
						if (!st.wl_zero) begin
							cmd.set_status = 1'b1;
							cmd.status = ST_SEQ;
						end else if (!st.room) begin
							cmd.set_status = 1'b1;
							cmd.status = ST_FULL;
						end else begin
							cmd.hdr0 = 1'b1;
							state_d = S_HDR1;
						end
					end
					OP_PUSH: begin
						if (st.wl_zero) begin
							cmd.set_status = 1'b1;
							cmd.status = ST_SEQ;
						end else begin
							cmd.push = 1'b1;
						end
					end
					OP_POP: begin
						if (st.rl_zero && st.empty) begin
							cmd.set_status = 1'b1;
							cmd.status = ST_EMPTY;
						end else if (st.rl_zero) begin
							cmd.rd_h0 = 1'b1;
							state_d = S_RDH1;
						end else begin
							state_d = S_POP;
						end
					end
					default: begin
						cmd.set_status = 1'b1;
						cmd.status = ST_SEQ;
					end
				endcase
			end
			S_HDR1: begin
				cmd.hdr1 = 1'b1;
				state_d = S_DONE;
			end
			S_RDH1: begin
				cmd.rd_h1 = 1'b1;
				state_d = S_RDH2;
			end
			S_RDH2: begin
				cmd.hdr_take = 1'b1;
				state_d = S_POP;
			end
			S_POP: begin
				cmd.pop_chk = 1'b1;
				state_d = st.rl_zero ? S_DONE : S_POPD;
			end
			S_POPD: begin
				cmd.pl_take = 1'b1;
				state_d = S_DONE;
			end
			S_DONE: begin
				if (st.out_free) begin
					cmd.emit = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ----- src/lpmr_dp.sv -----
// Datapath: ring memory, positions, counters, result assembly and output register.
`timescale 1ns / 1ps
module lpmr_dp import lpmr_pkg::*; #(
	parameter int RING_DEPTH = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        ring_size_we,
	input  logic [10:0] ring_size_wdata,
	input  in_t         in_data,
	output out_t        out_data,
	output logic        out_valid,
	input  logic        out_ready,
	input  cmd_t        cmd,
	output stat_t       st
);

	localparam int AW  = $clog2(RING_DEPTH);
	localparam int SW  = AW + 1;
	localparam int XW  = ((SW > 10) ? SW : 10) + 2;
	localparam int RST = (RING_DEPTH < 1024) ? RING_DEPTH : 1024;
	localparam logic [XW-1:0] HB = XW'(HEADER_BYTES);

	function automatic logic [AW-1:0] wrap(input logic [XW-1:0] x, input logic [XW-1:0] s);
		return AW'((x >= s) ? x - s : x);
	endfunction

	logic [SW-1:0] size_q;
	logic [AW-1:0] wp_q, pub_q, rp_q;
	logic [9:0]    wl_q, rl_q, rc_q, rlen_q;
	logic [7:0]    b0_q;
	in_t           in_q;
	out_t          res_q;
	out_t          res_d;

	logic [XW-1:0] sz, wpx, rpx, used, fr, skip, rgap;
	logic [AW-1:0] hp, rhp;
	logic          mem_we;
	logic [AW-1:0] waddr, raddr;
	logic [7:0]    wdata, rdata;
	logic [10:0]   cfg_v;

	assign sz   = XW'(size_q);
	assign wpx  = XW'(wp_q);
	assign rpx  = XW'(rp_q);
	assign used = (wpx >= rpx) ? wpx - rpx : sz - rpx + wpx;
	assign fr   = (used + HB >= sz) ? '0 : sz - used - HB;
	assign skip = (sz - wpx < HB) ? sz - wpx : '0;
	assign rgap = sz - rpx;
	assign hp   = (skip != '0) ? '0 : wp_q;
	assign rhp  = (rgap < HB) ? '0 : rp_q;

	assign st.op       = in_q.operation;
	assign st.wl_zero  = (wl_q == '0);
	assign st.rl_zero  = (rl_q == '0);
	assign st.empty    = (rp_q == pub_q);
	assign st.room     = (XW'(in_q.msg_length) + HB + skip <= fr);
	assign st.out_free = !out_valid || out_ready;

	always_comb begin
		mem_we = 1'b0;
		waddr  = wp_q;
		wdata  = in_q.data_in;
		raddr  = rp_q;
		if (cmd.hdr0) begin
			mem_we = 1'b1;
			waddr  = hp;
			wdata  = in_q.msg_length[7:0];
		end else if (cmd.hdr1) begin
			mem_we = 1'b1;
			waddr  = hp + AW'(1);
			wdata  = {6'b0, in_q.msg_length[9:8]};
		end else if (cmd.push) begin
			mem_we = 1'b1;
		end
		if (cmd.rd_h0) begin
			raddr = rhp;
		end else if (cmd.rd_h1) begin
			raddr = rhp + AW'(1);
		end
	end

	lpmr_ram #(.WIDTH(8), .DEPTH(RING_DEPTH)) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_comb begin
		cfg_v = ring_size_wdata;
		if (cfg_v < 11'd8) begin
			cfg_v = 11'd8;
		end
		if (32'(cfg_v) > 32'(RING_DEPTH)) begin
			cfg_v = 11'(RING_DEPTH);
		end
	end

	always_comb begin
		res_d            = res_q;
		res_d.free_bytes = fr[9:0];
		res_d.is_empty   = (rp_q == pub_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q    <= SW'(RST);
			wp_q      <= '0;
			pub_q     <= '0;
			rp_q      <= '0;
			wl_q      <= '0;
			rl_q      <= '0;
			rc_q      <= '0;
			rlen_q    <= '0;
			out_valid <= 1'b0;
		end else begin
			if (ring_size_we) begin
				size_q <= SW'(cfg_v);
				wp_q   <= '0;
				pub_q  <= '0;
				rp_q   <= '0;
				wl_q   <= '0;
				rl_q   <= '0;
				rc_q   <= '0;
				rlen_q <= '0;
			end
			if (cmd.hdr1) begin
				wp_q <= wrap(XW'(hp) + HB, sz);
				wl_q <= in_q.msg_length;
				if (in_q.msg_length == '0) begin
					pub_q <= wrap(XW'(hp) + HB, sz);
				end
			end
			if (cmd.push) begin
				wp_q <= wrap(wpx + XW'(1), sz);
				wl_q <= wl_q - 10'd1;
				if (wl_q == 10'd1) begin
					pub_q <= wrap(wpx + XW'(1), sz);
				end
			end
			if (cmd.hdr_take) begin
				rl_q   <= {rdata[1:0], b0_q};
				rlen_q <= {rdata[1:0], b0_q};
				rp_q   <= wrap(XW'(rhp) + HB, sz);
				rc_q   <= '0;
			end
			if (cmd.pl_take) begin
				rp_q <= wrap(rpx + XW'(1), sz);
				rc_q <= rc_q + 10'd1;
				rl_q <= rl_q - 10'd1;
			end
			if (cmd.emit) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			in_q  <= in_data;
			res_q <= '0;
		end
		if (cmd.set_status) begin
			res_q.status <= cmd.status;
		end
		if (cmd.rd_h1) begin
			b0_q <= rdata;
		end
		if (cmd.hdr_take) begin
			res_q.first_byte <= 1'b1;
		end
		if (cmd.pop_chk) begin
			res_q.popped_length <= rlen_q;
			if (rl_q == '0) begin
				res_q.last_byte <= 1'b1;
			end
		end
		if (cmd.pl_take) begin
			res_q.data_out  <= rdata;
			res_q.kept      <= (rc_q < in_q.read_limit);
			res_q.last_byte <= (rl_q == 10'd1);
		end
		if (cmd.emit) begin
			out_data <= res_d;
		end
	end

endmodule

// ----- src/length_prefixed_message_ring.sv -----
// Top level of the length-prefixed message ring.
//
// Input words carry an operation: begin a message with its length, push one
// payload byte, or pop one payload byte. Every accepted word yields exactly
// one result word with a status, the popped byte and its flags, the free
// space and the empty flag. Both channels are valid/ready.
// ring_size is written through ring_size_we/ring_size_wdata and clears all
// positions, leaving the ring empty.
// One word is in work at a time; the single byte-wide memory port sets the
// order of steps: a begin writes the two header bytes in turn, a push writes
// one payload byte, a pop reads one payload byte if any, first reading the two
// header bytes when no message is open. Rejected words go straight to
// their result. A new word is accepted once the result is registered.
// When the receiver stalls, one result waits in the output register while
// the next word is accepted and worked on; that word then holds until the
// register is free. Reset empties the ring and sets ring_size to the
// smaller of RING_DEPTH and 1024; memory contents are not cleared.
`timescale 1ns / 1ps
module length_prefixed_message_ring import lpmr_pkg::*; #(
	parameter int RING_DEPTH = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        ring_size_we,
	input  logic [10:0] ring_size_wdata,
	input  logic        in_valid,
	output logic        in_ready,
	input  in_t         in_data,
	output logic        out_valid,
	input  logic        out_ready,
	output out_t        out_data
);

	cmd_t  cmd;
	stat_t st;

	lpmr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.st       (st),
		.cmd      (cmd)
	);

	lpmr_dp #(.RING_DEPTH(RING_DEPTH)) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.ring_size_we    (ring_size_we),
		.ring_size_wdata (ring_size_wdata),
		.in_data         (in_data),
		.out_data        (out_data),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.cmd             (cmd),
		.st              (st)
	);

`ifndef SYNTHESIS
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("accepted a word while busy");
	a_hdr_pair: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.hdr0 |=> cmd.hdr1)
		else $error("header write not completed");
	a_rdh_pair: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rd_h0 |=> cmd.rd_h1)
		else $error("header read not completed");
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> (!out_valid || out_ready))
		else $error("result overwritten");
`endif

endmodule
